// File: hdl/ppsch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsch_pkg
// Shared types and constants of the priority process scheduler.
// ----------------------------------------------------------------------------
package ppsch_pkg;

  localparam int ProcessesDef = 16;
  localparam int QuantumW     = 16;
  localparam int IdW          = 16;
  localparam int TimeW        = 16;
  localparam int PrioW        = 8;
  localparam int LatW         = 32;
  localparam int SlotW        = 4;
  localparam int StatusW      = 2;
  localparam int InDataW      = 40;
  localparam int OutDataW     = 88;
  localparam int OutPadW      = OutDataW - (SlotW + IdW + 2 * TimeW + LatW + 1);

  typedef enum logic [StatusW-1:0] {
    ST_RAN   = 2'd0,
    ST_IDLE  = 2'd1,
    ST_ADDED = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CALC,
    S_UPD,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LatW-1:0]  latency;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] time_left;
    logic [IdW-1:0]   id;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   out_id;
    logic [TimeW-1:0] time_used;
    logic [TimeW-1:0] time_left;
    logic [LatW-1:0]  latency;
    logic             finished;
  } res_t;

  typedef struct packed {
    logic capture;
    logic pass_clr;
    logic pass_run;
    logic upd_mode;
    logic do_add;
    logic do_calc;
    logic fin_ran;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_sched;
    logic pass_end;
    logic none_found;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/ppsch_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsch_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppsch_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/ppsch_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsch_ctrl
// Sequencer of the scheduler: decode, scan pass, update pass, result hand-off.
// ----------------------------------------------------------------------------
module ppsch_ctrl
  import ppsch_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.pass_clr = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_sched) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.do_add = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.pass_run = 1'b1;
        if (stat_i.pass_end) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.do_calc  = 1'b1;
        cmd_o.pass_clr = 1'b1;
        state_d        = stat_i.none_found ? S_DONE : S_UPD;
      end
      S_UPD: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.upd_mode = 1'b1;
        if (stat_i.pass_end) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin_ran = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/ppsch_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsch_dp
// Datapath: process table, scan compare, quantum arithmetic, output register.
// ----------------------------------------------------------------------------
module ppsch_dp
  import ppsch_pkg::*;
#(
  parameter int PROCESSES = ProcessesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output stat_t                    stat_o,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic                in_kind_i,
  input  wire logic                cfg_we_i,
  input  wire logic [QuantumW-1:0] cfg_wdata_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [OutDataW-1:0]      out_data_o,
  output logic [StatusW-1:0]       out_status_o
);

  localparam int AW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CW = $clog2(PROCESSES + 1);

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic                out_vld_q, out_vld_d;
  logic [QuantumW-1:0] quantum_q, quantum_d;

  logic             kind_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] rt_q;
  logic [PrioW-1:0] prio_q;
  logic [AW-1:0]    rd_idx_q;
  logic [PrioW-1:0] best_q;
  logic [AW-1:0]    pos_q;
  logic [IdW-1:0]   sel_id_q;
  logic [TimeW-1:0] sel_left_q;
  logic [TimeW-1:0] used_q;
  logic [TimeW-1:0] left_new_q;
  logic [LatW-1:0]  lat_q;
  res_t             res_q, res_d;
  res_t             out_q;

  entry_t           rd_entry, upd_entry, add_entry, wr_entry;
  logic             full, issue, scan_hit, upd_we, add_we, ram_we, is_pos;
  logic [AW-1:0]    ram_waddr;
  logic [TimeW-1:0] used_c;
  logic [LatW:0]    lat_sum;
  logic [LatW-1:0]  lat_new;
  logic [AW+SlotW-1:0] cnt_slot_w, pos_slot_w;

  assign full     = (count_q == CW'(PROCESSES));
  assign issue    = cmd_i.pass_run && (cnt_q != count_q);
  assign scan_hit = cmd_i.pass_run && !cmd_i.upd_mode && rd_vld_q &&
                    (rd_entry.prio > best_q) && (rd_entry.time_left != '0);
  assign upd_we   = cmd_i.pass_run && cmd_i.upd_mode && rd_vld_q;
  assign add_we   = cmd_i.do_add && !full;
  assign ram_we   = add_we || upd_we;
  assign is_pos   = (rd_idx_q == pos_q);

  assign cnt_slot_w = {{SlotW{1'b0}}, count_q[AW-1:0]};
  assign pos_slot_w = {{SlotW{1'b0}}, pos_q};

  assign used_c  = (quantum_q < sel_left_q) ? quantum_q : sel_left_q;
  assign lat_sum = {1'b0, rd_entry.latency} + {{(LatW + 1 - TimeW){1'b0}}, used_q};
  assign lat_new = lat_sum[LatW] ? {LatW{1'b1}} : lat_sum[LatW-1:0];

  always_comb begin
    upd_entry = rd_entry;
    if (rd_entry.prio != '0) begin
      upd_entry.latency = lat_new;
    end
    if (is_pos) begin
      upd_entry.time_left = left_new_q;
      if (left_new_q == '0) begin
        upd_entry.prio = '0;
      end
    end
  end

  always_comb begin
    add_entry.latency   = '0;
    add_entry.prio      = prio_q;
    add_entry.time_left = rt_q;
    add_entry.id        = id_q;
  end

  assign wr_entry  = add_we ? add_entry : upd_entry;
  assign ram_waddr = add_we ? count_q[AW-1:0] : rd_idx_q;

  ppsch_ram #(
    .Width(EntryW),
    .Depth(PROCESSES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (issue),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rd_entry)
  );

  always_comb begin
    count_d   = add_we ? count_q + CW'(1) : count_q;
    quantum_d = cfg_we_i ? cfg_wdata_i : quantum_q;
    cnt_d     = cnt_q;
    rd_vld_d  = issue;
    if (cmd_i.pass_clr) begin
      cnt_d    = '0;
      rd_vld_d = 1'b0;
    end else if (issue) begin
      cnt_d = cnt_q + CW'(1);
    end
    out_vld_d = out_vld_q;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.do_add) begin
      res_d        = '0;
      res_d.out_id = id_q;
      if (full) begin
        res_d.status = ST_FULL;
      end else begin
        res_d.status    = ST_ADDED;
        res_d.slot      = cnt_slot_w[SlotW-1:0];
        res_d.time_left = rt_q;
      end
    end else if (cmd_i.do_calc && (best_q == '0)) begin
      res_d        = '0;
      res_d.status = ST_IDLE;
    end else if (cmd_i.fin_ran) begin
      res_d.status    = ST_RAN;
      res_d.slot      = pos_slot_w[SlotW-1:0];
      res_d.out_id    = sel_id_q;
      res_d.time_used = used_q;
      res_d.time_left = left_new_q;
      res_d.latency   = lat_q;
      res_d.finished  = (left_new_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      quantum_q <= QuantumW'(1);
    end else begin
      count_q   <= count_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      quantum_q <= quantum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      id_q   <= in_data_i[IdW-1:0];
      rt_q   <= in_data_i[IdW+TimeW-1:IdW];
      prio_q <= in_data_i[IdW+TimeW+PrioW-1:IdW+TimeW];
      best_q <= '0;
    end else if (scan_hit) begin
      best_q <= rd_entry.prio;
    end
    if (issue) begin
      rd_idx_q <= cnt_q[AW-1:0];
    end
    if (scan_hit) begin
      pos_q      <= rd_idx_q;
      sel_id_q   <= rd_entry.id;
      sel_left_q <= rd_entry.time_left;
    end
    if (cmd_i.do_calc) begin
      used_q     <= used_c;
      left_new_q <= sel_left_q - used_c;
    end
    if (upd_we && is_pos) begin
      lat_q <= lat_new;
    end
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign stat_o.is_sched   = kind_q;
  assign stat_o.pass_end   = (cnt_q == count_q);
  assign stat_o.none_found = (best_q == '0);
  assign stat_o.out_busy   = out_vld_q && !out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_q.status;
  assign out_data_o   = {{OutPadW{1'b0}}, out_q.finished, out_q.latency, out_q.time_left,
                         out_q.time_used, out_q.out_id, out_q.slot};

endmodule
`default_nettype wire

// File: hdl/priority_process_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_process_scheduler
// Table of processes with a priority pick and a time quantum per step.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis group: tuser = 0 adds a process, tuser = 1
// runs one schedule step. Every item gives exactly one result item on the
// m_axis group, whose tuser carries the status code. cfg_we_i writes the
// quantum in ticks; write it only while the block is idle.
// A schedule step that runs an entry makes one pass over the table RAM to
// pick the entry and one read-modify-write pass to add the used time to the
// latency of every entry with nonzero priority; an idle step makes only the
// first pass. Each pass reads one table entry per cycle on the single RAM
// read port.
// The next item is accepted in the cycle after the result enters the output
// register, while that result still waits to be taken. If the receiver
// stalls, the finished result of the next item waits until the output
// register is free. Reset empties the table, sets the quantum to 1 and
// drops any result not yet taken.
// ----------------------------------------------------------------------------
module priority_process_scheduler
  import ppsch_pkg::*;
#(
  parameter int PROCESSES = ProcessesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // proc_id [15:0], run_time [31:16], prio [39:32]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // kind [0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // slot [3:0], out_id [19:4], time_used [35:20], time_left [51:36],
  // latency [83:52], finished [84], zero [87:85]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // status [1:0]
  output logic [StatusW-1:0]       m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [QuantumW-1:0] cfg_wdata_i
);

  cmd_t  cmd;
  stat_t stat;

  ppsch_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ppsch_dp #(
    .PROCESSES(PROCESSES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_status_o(m_axis_tuser)
  );

endmodule
`default_nettype wire

// File: hdl/ppsch_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsch_chk
// Port-level checks of the scheduler result stream.
// ----------------------------------------------------------------------------
module ppsch_chk
  import ppsch_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [StatusW-1:0]  m_axis_tuser
);

  logic             fin;
  logic [TimeW-1:0] used, left;
  logic [LatW-1:0]  lat;
  logic [SlotW-1:0] slot;

  assign slot = m_axis_tdata[3:0];
  assign used = m_axis_tdata[35:20];
  assign left = m_axis_tdata[51:36];
  assign lat  = m_axis_tdata[83:52];
  assign fin  = m_axis_tdata[84];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_IDLE) |-> (m_axis_tdata == '0))
    else $error("idle result carries data");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      (slot == '0) && (used == '0) && (left == '0) && (lat == '0) && !fin)
    else $error("table-full result carries data");

  a_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ADDED) |->
      (used == '0) && (lat == '0) && !fin)
    else $error("added result carries run data");

  a_ran_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_RAN) |-> (fin == (left == '0)))
    else $error("finished flag disagrees with time left");

endmodule

bind priority_process_scheduler ppsch_chk u_ppsch_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
